// File: src/rfgt_pkg.sv
// Shared constants and types for the reservation first-gap tracker.
`timescale 1ns / 1ps
`default_nettype none

package rfgt_pkg;

	// Default table depth and byte offset width
	localparam int unsigned MAX_RANGES_DEF  = 64;
	localparam int unsigned OFFSET_BITS_DEF = 40;

	// Operation codes of the func field
	localparam logic FUNC_RESERVE = 1'b0;
	localparam logic FUNC_QUERY   = 1'b1;

	// Result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic rot;     // rotate the whole row toward cell zero
		logic ins;     // sorted insert of the pending range
		logic occ;     // this cell holds a live entry
		logic at_end;  // this cell is the first free slot
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/reservation_first_gap_tracker.sv
// Top level: sequencer, row of table cells and the gap walker.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to MAX_RANGES reserved byte ranges sorted by start, then length,
// in a row of cells. A reserve (func 0) shifts the row open and inserts; done
// rises when the ST_INS state that follows the accepting edge ends, with status
// 1 when the table was already full. A query (func 1) rotates the whole row
// once through the head cell, one entry per cycle, and done rises when the
// ST_QEND state after the rotation ends, with the first uncovered offset on
// gap_offset. The row rotation sets the query time. busy falls as done rises,
// so start may be raised again in the cycle that done is high; a new item is
// accepted only once the previous one is done. done lasts one cycle and cannot
// be held off.
module reservation_first_gap_tracker
	import rfgt_pkg::*;
#(
	parameter int unsigned MAX_RANGES  = MAX_RANGES_DEF,
	parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   func,
	input  wire logic [OFFSET_BITS-1:0] range_start,
	input  wire logic [OFFSET_BITS-1:0] range_length,
	output logic                        done,
	output logic [OFFSET_BITS:0]        gap_offset,
	output logic                        status
);

	localparam int unsigned IDX_W = $clog2(MAX_RANGES);
	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_QRY  = 2'd2;
	localparam logic [1:0] ST_QEND = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       walk_q;
	logic [OFFSET_BITS-1:0] new_start_q;
	logic [OFFSET_BITS-1:0] new_length_q;
	logic                   done_q;
	logic [OFFSET_BITS:0]   gap_q;
	logic                   status_q;

	logic                   accept;
	logic                   full;
	logic                   do_ins;
	logic                   do_rot;
	logic [OFFSET_BITS:0]   covered;

	logic [OFFSET_BITS-1:0] cell_start  [MAX_RANGES];
	logic [OFFSET_BITS-1:0] cell_length [MAX_RANGES];
	logic                   cell_after  [MAX_RANGES];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_RANGES));
	assign do_ins = (state_q == ST_INS) && !full;
	assign do_rot = (state_q == ST_QRY);

	assign done       = done_q;
	assign gap_offset = gap_q;
	assign status     = status_q;

	// Latch the pending range on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			new_start_q  <= range_start;
			new_length_q <= range_length;
		end
	end

	// Sequence reserve and query beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			walk_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					walk_q <= '0;
					if (accept) begin
						state_q <= (func == FUNC_QUERY) ? ST_QRY : ST_INS;
					end
				end
				ST_INS: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_QRY: begin
					walk_q <= walk_q + IDX_W'(1);
					if (walk_q == IDX_W'(MAX_RANGES - 1)) begin
						state_q <= ST_QEND;
					end
				end
				ST_QEND: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result beat payload
	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			gap_q    <= '0;
			status_q <= full ? STATUS_FULL : STATUS_OK;
		end else if (state_q == ST_QEND) begin
			gap_q    <= covered;
			status_q <= STATUS_OK;
		end
	end

	// Row of cells; the tail takes the head so a query rotates the table
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		cell_ctrl_t             ctrl;
		logic [OFFSET_BITS-1:0] l_start;
		logic [OFFSET_BITS-1:0] l_length;
		logic                   l_after;
		logic [OFFSET_BITS-1:0] r_start;
		logic [OFFSET_BITS-1:0] r_length;

		assign ctrl = '{
			rot:    do_rot,
			ins:    do_ins,
			occ:    (CNT_W'(i) < count_q),
			at_end: (CNT_W'(i) == count_q)
		};

		if (i == 0) begin : g_head
			assign l_start  = '0;
			assign l_length = '0;
			assign l_after  = 1'b0;
		end else begin : g_body
			assign l_start  = cell_start[i-1];
			assign l_length = cell_length[i-1];
			assign l_after  = cell_after[i-1];
		end

		if (i == MAX_RANGES - 1) begin : g_tail
			assign r_start  = cell_start[0];
			assign r_length = cell_length[0];
		end else begin : g_mid
			assign r_start  = cell_start[i+1];
			assign r_length = cell_length[i+1];
		end

		rfgt_cell #(
			.OFFSET_BITS(OFFSET_BITS)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_start   (new_start_q),
			.new_length  (new_length_q),
			.left_start  (l_start),
			.left_length (l_length),
			.left_after  (l_after),
			.right_start (r_start),
			.right_length(r_length),
			.start_q     (cell_start[i]),
			.length_q    (cell_length[i]),
			.after       (cell_after[i])
		);
	end

	// Walk the head cell as the row rotates
	rfgt_walk #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (accept),
		.step        (do_rot),
		.entry_valid (CNT_W'(walk_q) < count_q),
		.entry_start (cell_start[0]),
		.entry_length(cell_length[0]),
		.covered_q   (covered)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RANGES))
		else $error("entry count past table depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_INS || $past(state_q) == ST_QEND))
		else $error("result beat without finished work");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STATUS_FULL) |-> (full && gap_q == '0))
		else $error("drop flagged while table not full");
`endif

endmodule

`default_nettype wire

// File: src/rfgt_cell.sv
// One table cell: holds a (start, length) entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module rfgt_cell
	import rfgt_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire cell_ctrl_t             ctrl,
	input  wire logic [OFFSET_BITS-1:0] new_start,
	input  wire logic [OFFSET_BITS-1:0] new_length,
	input  wire logic [OFFSET_BITS-1:0] left_start,
	input  wire logic [OFFSET_BITS-1:0] left_length,
	input  wire logic                   left_after,
	input  wire logic [OFFSET_BITS-1:0] right_start,
	input  wire logic [OFFSET_BITS-1:0] right_length,
	output logic [OFFSET_BITS-1:0]      start_q,
	output logic [OFFSET_BITS-1:0]      length_q,
	output logic                        after
);

	// Flag a live entry that sorts strictly after the pending range
	always_comb begin
		if (start_q != new_start) begin
			after = ctrl.occ && (start_q > new_start);
		end else begin
			after = ctrl.occ && (length_q > new_length);
		end
	end

	// Rotate, shift right to open a slot, or take the pending range
	always_ff @(posedge clk) begin
		if (ctrl.rot) begin
			start_q  <= right_start;
			length_q <= right_length;
		end else if (ctrl.ins) begin
			if (left_after) begin
				start_q  <= left_start;
				length_q <= left_length;
			end else if (after || ctrl.at_end) begin
				start_q  <= new_start;
				length_q <= new_length;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/rfgt_walk.sv
// Covered-prefix accumulator fed one entry per cycle from the head cell while step is high.
`timescale 1ns / 1ps
`default_nettype none

module rfgt_walk
	import rfgt_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   clear,
	input  wire logic                   step,
	input  wire logic                   entry_valid,
	input  wire logic [OFFSET_BITS-1:0] entry_start,
	input  wire logic [OFFSET_BITS-1:0] entry_length,
	output logic [OFFSET_BITS:0]        covered_q
);

	logic                stop_q;
	logic [OFFSET_BITS:0] stop_sum;
	logic                gap_hit;

	assign stop_sum = {1'b0, entry_start} + {1'b0, entry_length};
	assign gap_hit  = {1'b0, entry_start} > covered_q;

	// Extend the prefix until the first entry that leaves a gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q    <= 1'b0;
			covered_q <= '0;
		end else if (clear) begin
			stop_q    <= 1'b0;
			covered_q <= '0;
		end else if (step && entry_valid && !stop_q) begin
			if (gap_hit) begin
				stop_q <= 1'b1;
			end else if (stop_sum > covered_q) begin
				covered_q <= stop_sum;
			end
		end
	end

endmodule

`default_nettype wire
